// ===== rtl/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// sha_pkg: shared types and constants of the SASI host adapter port block
//
// Holds the request and result beat layouts, the port and control-bit
// constants, the configuration register indexes and the small decode
// functions for the gate network and the drive-type switches.
// ----------------------------------------------------------------------------
package sha_pkg;

   // Request kinds carried in the req_type field.
   typedef enum logic [1:0] {
      REQ_PORT_WRITE = 2'd0,
      REQ_PORT_READ  = 2'd1,
      REQ_LINE_EVENT = 2'd2,
      REQ_TERM_COUNT = 2'd3
   } req_kind_type;

   // Configuration register indexes; register i sits at byte address 4*i.
   typedef enum logic [2:0] {
      CFG_DISK0_PRESENT    = 3'd0,
      CFG_DISK0_SIZE_MB    = 3'd1,
      CFG_DISK0_FOUR_HEADS = 3'd2,
      CFG_DISK0_SECTOR512  = 3'd3,
      CFG_DISK1_PRESENT    = 3'd4,
      CFG_DISK1_SIZE_MB    = 3'd5,
      CFG_DISK1_FOUR_HEADS = 3'd6,
      CFG_DISK1_SECTOR512  = 3'd7
   } cfg_index_type;

   localparam int CsrAddrWidth = 5;
   localparam int CsrDataWidth = 32;

   // Host I/O port addresses.
   localparam logic [15:0] DataPort    = 16'h0080;
   localparam logic [15:0] ControlPort = 16'h0082;
   localparam logic [7:0]  UnmappedRead = 8'hFF;

   // Control register bit positions.
   localparam int CtlNrdswBit = 6;
   localparam int CtlSelBit   = 5;
   localparam int CtlRstBit   = 3;
   localparam int CtlDmaeBit  = 1;
   localparam int CtlInteBit  = 0;

   // Line flag bit positions; the bit number is the signal id.
   localparam int NumLines    = 6;
   localparam int LineCxdBit  = 1;
   localparam int LineIxoBit  = 2;
   localparam int LineMsgBit  = 3;
   localparam int LineReqBit  = 4;
   localparam int LineAckBit  = 5;
   localparam logic [2:0] LastSignalId = 3'd5;

   // Drive type size thresholds in megabytes.
   localparam logic [11:0] SizeType0Max = 12'd6;
   localparam logic [11:0] SizeType1Max = 12'd11;
   localparam logic [11:0] SizeType2Max = 12'd16;
   localparam logic [11:0] SizeType3Max = 12'd21;
   localparam logic [11:0] SizeType5Max = 12'd31;
   localparam logic [2:0]  TypeAbsent   = 3'd7;

   // Request beat.
   typedef struct packed {
      req_kind_type req_type;
      logic [15:0]  port_addr;
      logic [7:0]   write_data;
      logic [2:0]   signal_id;
      logic         signal_level;
      logic [7:0]   target_read_data;
      logic         bus_req;
      logic         bus_bsy;
      logic         bus_msg;
      logic         bus_cd;
      logic         bus_io;
   } req_item_type;

   // Result beat.
   typedef struct packed {
      logic [7:0] read_data;
      logic       target_write;
      logic       target_read;
      logic [7:0] target_write_data;
      logic       rst_level;
      logic       sel_level;
      logic       irq;
      logic       drq;
   } rsp_item_type;

   // Outputs of the glue-gate network.
   typedef struct packed {
      logic a;
      logic d;
   } gate_out_type;

   // Gate network on the negated line flags and the DMA enable bit.
   function automatic gate_out_type gates(input logic dmae, input logic [NumLines-1:0] flags);
      gate_out_type g;
      logic         b;
      logic         c;
      g.a = !flags[LineReqBit] && flags[LineCxdBit];
      b   = !(!flags[LineReqBit] && !flags[LineIxoBit] && flags[LineMsgBit]
              && !flags[LineCxdBit]);
      c   = !(!dmae && g.a);
      g.d = !(b && c);
      return g;
   endfunction

   // Drive-type switch code of one disk.
   function automatic logic [2:0] drive_type(input logic present, input logic [11:0] size_mb,
                                             input logic four_heads);
      logic [2:0] t;
      if (!present) begin
         t = TypeAbsent;
      end else if (size_mb <= SizeType0Max) begin
         t = 3'd0;
      end else if (size_mb <= SizeType1Max) begin
         t = 3'd1;
      end else if (size_mb <= SizeType2Max) begin
         t = 3'd2;
      end else if (size_mb <= SizeType3Max) begin
         t = four_heads ? 3'd4 : 3'd3;
      end else if (size_mb <= SizeType5Max) begin
         t = 3'd5;
      end else begin
         t = 3'd6;
      end
      return t;
   endfunction

endpackage

// ===== rtl/sasi_host_adapter_ports_unit.sv =====
// ----------------------------------------------------------------------------
// sasi_host_adapter_ports_unit: SASI host adapter port block
//
// Top level: request register, handshake control, configuration registers
// and the decode core with its result register.
// ----------------------------------------------------------------------------
// The block takes one request beat per clock while the input is not stalled,
// and returns exactly one result beat for each, in order. A request passes
// through the input register and then the result register. The state update
// of the control register, line flags and request flags is committed as each
// request moves into the result register. A finished result may wait in the
// result register while the next request is taken; the input stalls only
// when both registers are full and the result side stalls. Disk configuration
// must be written through the APB port only while no request is in flight;
// the block itself does not enforce it.
module sasi_host_adapter_ports_unit
   import sha_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  req_item_type            req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rsp_item_type            rsp_data,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CsrAddrWidth-1:0] paddr,
   input  logic [CsrDataWidth-1:0] pwdata,
   output logic [CsrDataWidth-1:0] prdata,
   output logic                    pready
);

   logic         s1_valid_ff, s1_valid_in;
   req_item_type s1_item_ff;
   logic         room;
   logic         advance;
   logic [7:0]   switch_byte;

   // Handshake: the input register moves on whenever the result side has room.
   assign advance     = s1_valid_ff && room;
   assign req_stall   = s1_valid_ff && !room;
   assign s1_valid_in = req_stall ? 1'b1 : req_valid;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_item_ff <= req_data;
      end
   end

   // Disk configuration registers.
   sha_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .switch_byte (switch_byte)
   );

   // Decode, state and result register.
   sha_core u_core (
      .clock       (clock),
      .reset       (reset),
      .load        (advance),
      .item        (s1_item_ff),
      .switch_byte (switch_byte),
      .rsp_stall   (rsp_stall),
      .room        (room),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

   // The input only stalls behind a held request.
   a_stall_needs_held: assert property (@(posedge clock)
      req_stall |-> s1_valid_ff)
      else $error("input stalled with an empty input register");

   // Both pipeline registers are empty after reset.
   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid && !s1_valid_ff)
      else $error("pipeline not empty after reset");

   // A data-port access pulses at most one target strobe.
   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.target_write && rsp_data.target_read))
      else $error("target read and write pulsed together");

endmodule

// ===== rtl/sha_csr.sv =====
// ----------------------------------------------------------------------------
// sha_csr: disk configuration registers
//
// APB-style register file holding the two disk descriptions, and the
// drive-type switch byte that a control-port read returns while NRDSW is clear.
// ----------------------------------------------------------------------------
module sha_csr
   import sha_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CsrAddrWidth-1:0] paddr,
   input  logic [CsrDataWidth-1:0] pwdata,
   output logic [CsrDataWidth-1:0] prdata,
   output logic                    pready,
   output logic [7:0]              switch_byte
);

   logic        d0_present_ff;
   logic [11:0] d0_size_ff;
   logic        d0_four_ff;
   logic        d0_sec512_ff;
   logic        d1_present_ff;
   logic [11:0] d1_size_ff;
   logic        d1_four_ff;
   logic        d1_sec512_ff;

   cfg_index_type idx;
   logic          wr_en;

   assign pready = 1'b1;
   assign idx    = cfg_index_type'(paddr[4:2]);
   assign wr_en  = psel && penable && pwrite;

   // Register writes in the access phase.
   always_ff @(posedge clock) begin
      if (reset) begin
         d0_present_ff <= 1'b0;
         d0_size_ff    <= 12'd0;
         d0_four_ff    <= 1'b0;
         d0_sec512_ff  <= 1'b0;
         d1_present_ff <= 1'b0;
         d1_size_ff    <= 12'd0;
         d1_four_ff    <= 1'b0;
         d1_sec512_ff  <= 1'b0;
      end else if (wr_en) begin
         case (idx)
            CFG_DISK0_PRESENT:    d0_present_ff <= pwdata[0];
            CFG_DISK0_SIZE_MB:    d0_size_ff    <= pwdata[11:0];
            CFG_DISK0_FOUR_HEADS: d0_four_ff    <= pwdata[0];
            CFG_DISK0_SECTOR512:  d0_sec512_ff  <= pwdata[0];
            CFG_DISK1_PRESENT:    d1_present_ff <= pwdata[0];
            CFG_DISK1_SIZE_MB:    d1_size_ff    <= pwdata[11:0];
            CFG_DISK1_FOUR_HEADS: d1_four_ff    <= pwdata[0];
            CFG_DISK1_SECTOR512:  d1_sec512_ff  <= pwdata[0];
            default: ;
         endcase
      end
   end

   // Read-back mux.
   always_comb begin
      prdata = '0;
      case (idx)
         CFG_DISK0_PRESENT:    prdata[0]    = d0_present_ff;
         CFG_DISK0_SIZE_MB:    prdata[11:0] = d0_size_ff;
         CFG_DISK0_FOUR_HEADS: prdata[0]    = d0_four_ff;
         CFG_DISK0_SECTOR512:  prdata[0]    = d0_sec512_ff;
         CFG_DISK1_PRESENT:    prdata[0]    = d1_present_ff;
         CFG_DISK1_SIZE_MB:    prdata[11:0] = d1_size_ff;
         CFG_DISK1_FOUR_HEADS: prdata[0]    = d1_four_ff;
         CFG_DISK1_SECTOR512:  prdata[0]    = d1_sec512_ff;
         default:              prdata       = '0;
      endcase
   end

   // Switch byte: sector bits on top, then disk0 and disk1 type codes.
   assign switch_byte = {d0_present_ff && d0_sec512_ff,
                         d1_present_ff && d1_sec512_ff,
                         drive_type(d0_present_ff, d0_size_ff, d0_four_ff),
                         drive_type(d1_present_ff, d1_size_ff, d1_four_ff)};

endmodule

// ===== rtl/sha_core.sv =====
// ----------------------------------------------------------------------------
// sha_core: port decode, adapter state and result register
//
// Decodes one registered request, updates the control register, the line
// flags and the two request flags, and loads the result register.
// ----------------------------------------------------------------------------
module sha_core
   import sha_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  req_item_type item,
   input  logic [7:0]   switch_byte,
   input  logic         rsp_stall,
   output logic         room,
   output logic         rsp_valid,
   output rsp_item_type rsp_data
);

   logic [7:0]          ctl_ff, ctl_in;
   logic [NumLines-1:0] flags_ff, flags_in;
   logic                irq_ff, irq_in;
   logic                drq_ff, drq_in;
   logic                out_valid_ff;
   rsp_item_type        out_ff, out_in;
   gate_out_type        g_old, g_new;
   logic [7:0]          status_byte;

   assign room      = !out_valid_ff || !rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // Live bus status with the interrupt flag.
   assign status_byte = {item.bus_req, 1'b0, item.bus_bsy, item.bus_msg,
                         item.bus_cd, item.bus_io, 1'b0, irq_ff};

   // Request decode and next state.
   always_comb begin
      ctl_in   = ctl_ff;
      flags_in = flags_ff;
      out_in   = '0;
      case (item.req_type)
         REQ_PORT_WRITE: begin
            if (item.port_addr == DataPort) begin
               out_in.target_write      = 1'b1;
               out_in.target_write_data = item.write_data;
            end else if (item.port_addr == ControlPort) begin
               ctl_in = item.write_data;
            end
         end
         REQ_PORT_READ: begin
            if (item.port_addr == DataPort) begin
               out_in.target_read = 1'b1;
               out_in.read_data   = item.target_read_data;
            end else if (item.port_addr == ControlPort) begin
               out_in.read_data = ctl_ff[CtlNrdswBit] ? status_byte : switch_byte;
            end else begin
               out_in.read_data = UnmappedRead;
            end
         end
         REQ_LINE_EVENT: begin
            if (item.signal_id <= LastSignalId) begin
               for (int i = 0; i < NumLines; i++) begin
                  if (item.signal_id == 3'(i)) begin
                     flags_in[i] = !item.signal_level;
                  end
               end
            end
         end
         REQ_TERM_COUNT: begin
            if (item.signal_level) begin
               ctl_in[CtlDmaeBit] = 1'b0;
            end
         end
         default: ;
      endcase

      // Gate network edges; no state change means no edge.
      g_old  = gates(ctl_ff[CtlDmaeBit], flags_ff);
      g_new  = gates(ctl_in[CtlDmaeBit], flags_in);
      irq_in = irq_ff;
      drq_in = drq_ff;
      if (!g_old.d && g_new.d) begin
         irq_in = ctl_in[CtlInteBit];
      end
      if (!g_old.a && g_new.a) begin
         drq_in = ctl_in[CtlDmaeBit];
      end
      if (ctl_ff[CtlInteBit] && !ctl_in[CtlInteBit]) begin
         irq_in = 1'b0;
      end
      if (ctl_ff[CtlDmaeBit] && !ctl_in[CtlDmaeBit]) begin
         drq_in = 1'b0;
      end
      if (flags_ff[LineAckBit] && !flags_in[LineAckBit]) begin
         drq_in = 1'b0;
      end

      out_in.rst_level = ctl_in[CtlRstBit];
      out_in.sel_level = ctl_in[CtlSelBit];
      out_in.irq       = irq_in;
      out_in.drq       = drq_in;
   end

   // Adapter state, committed when a request moves into the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff   <= '0;
         flags_ff <= '1;
         irq_ff   <= 1'b0;
         drq_ff   <= 1'b0;
      end else if (load) begin
         ctl_ff   <= ctl_in;
         flags_ff <= flags_in;
         irq_ff   <= irq_in;
         drq_ff   <= drq_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (load) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff <= out_in;
      end
   end

   // A request flag can only stand while its enable bit is set.
   a_irq_needs_inte: assert property (@(posedge clock) disable iff (reset)
      irq_ff |-> ctl_ff[CtlInteBit])
      else $error("irq flag set while INTE is clear");

   a_drq_needs_dmae: assert property (@(posedge clock) disable iff (reset)
      drq_ff |-> ctl_ff[CtlDmaeBit])
      else $error("drq flag set while DMAE is clear");

   a_no_load_without_room: assert property (@(posedge clock) disable iff (reset)
      load |-> room)
      else $error("result register loaded while full and stalled");

endmodule

// ===== tb/sv/sasi_host_adapter_ports_unit_tb.sv =====
// ----------------------------------------------------------------------------
// sasi_host_adapter_ports_unit_tb: self-checking bench for the SASI port block
//
// Sends port reads and writes, bus-line changes and terminal counts through
// the request channel while the disk switches are set over the APB port. A
// shadow copy of the control register, line flags and request flags works
// out the result beat for every accepted request, and each returned beat is
// compared field by field in arrival order. Both channels idle at random,
// and one stretch holds the result side off long enough to back up the input.
// ----------------------------------------------------------------------------
module sasi_host_adapter_ports_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sha_pkg::*;

   localparam int CycleLimit = 200000;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   req_item_type            req_data;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   rsp_item_type            rsp_data;
   logic                    psel;
   logic                    penable;
   logic                    pwrite;
   logic [CsrAddrWidth-1:0] paddr;
   logic [CsrDataWidth-1:0] pwdata;
   logic [CsrDataWidth-1:0] prdata;
   logic                    pready;

   // Shadow state of the block and its disk switches.
   logic [7:0]  ctl_shadow   = '0;
   logic [5:0]  lines_shadow = '1;
   logic        irq_shadow   = 1'b0;
   logic        drq_shadow   = 1'b0;
   logic        disk_present [2] = '{1'b0, 1'b0};
   logic [11:0] disk_size_mb [2] = '{12'd0, 12'd0};
   logic        disk_four_hd [2] = '{1'b0, 1'b0};
   logic        disk_sec512  [2] = '{1'b0, 1'b0};

   rsp_item_type pending_results[$];
   int           mismatches    = 0;
   int           send_idle_pct = 0;
   int           recv_idle_pct = 0;
   int           hold_left     = 0;
   int           cycle_count   = 0;

   sasi_host_adapter_ports_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("FAIL sasi_host_adapter_ports_unit");
         $finish;
      end
   end

   // Glue network on the negated line flags; returns {dma source, irq source}.
   function automatic logic [1:0] glue_levels(input logic [7:0] ctl, input logic [5:0] ln);
      logic dma_src;
      logic phase_ok;
      logic dma_ok;
      dma_src  = ln[LineCxdBit] & ~ln[LineReqBit];
      phase_ok = ~(~ln[LineReqBit] & ~ln[LineIxoBit] & ln[LineMsgBit] & ~ln[LineCxdBit]);
      dma_ok   = ~(dma_src & ~ctl[CtlDmaeBit]);
      return {dma_src, ~(phase_ok & dma_ok)};
   endfunction

   // Edge rules for the irq and drq flags, applied in priority order.
   function automatic void update_requests(input logic [7:0] prev_ctl,
                                           input logic [5:0] prev_lines);
      logic [1:0] was;
      logic [1:0] now;
      was = glue_levels(prev_ctl, prev_lines);
      now = glue_levels(ctl_shadow, lines_shadow);
      if (!was[0] && now[0]) irq_shadow = ctl_shadow[CtlInteBit];
      if (!was[1] && now[1]) drq_shadow = ctl_shadow[CtlDmaeBit];
      if (prev_ctl[CtlInteBit] && !ctl_shadow[CtlInteBit]) irq_shadow = 1'b0;
      if (prev_ctl[CtlDmaeBit] && !ctl_shadow[CtlDmaeBit]) drq_shadow = 1'b0;
      if (prev_lines[LineAckBit] && !lines_shadow[LineAckBit]) drq_shadow = 1'b0;
   endfunction

   // Drive-type switch code of one disk.
   function automatic logic [2:0] switch_code(input logic unit);
      logic [11:0] mb;
      mb = disk_size_mb[unit];
      if (!disk_present[unit]) return TypeAbsent;
      if (mb > SizeType5Max) return 3'd6;
      if (mb > SizeType3Max) return 3'd5;
      if (mb > SizeType2Max) return disk_four_hd[unit] ? 3'd4 : 3'd3;
      if (mb > SizeType1Max) return 3'd2;
      if (mb > SizeType0Max) return 3'd1;
      return 3'd0;
   endfunction

   // Expected result beat of one request; advances the shadow state.
   function automatic rsp_item_type port_block_outcome(input req_item_type it);
      rsp_item_type r;
      logic [7:0]   prev_ctl;
      logic [5:0]   prev_lines;
      logic         touched;
      r          = '0;
      prev_ctl   = ctl_shadow;
      prev_lines = lines_shadow;
      touched    = 1'b0;
      case (it.req_type)
         REQ_PORT_WRITE: begin
            if (it.port_addr == DataPort) begin
               r.target_write      = 1'b1;
               r.target_write_data = it.write_data;
            end else if (it.port_addr == ControlPort) begin
               ctl_shadow = it.write_data;
               touched    = 1'b1;
            end
         end
         REQ_PORT_READ: begin
            if (it.port_addr == DataPort) begin
               r.target_read = 1'b1;
               r.read_data   = it.target_read_data;
            end else if (it.port_addr == ControlPort) begin
               if (ctl_shadow[CtlNrdswBit]) begin
                  r.read_data = {it.bus_req, 1'b0, it.bus_bsy, it.bus_msg, it.bus_cd,
                                 it.bus_io, 1'b0, irq_shadow};
               end else begin
                  r.read_data = {disk_present[0] & disk_sec512[0],
                                 disk_present[1] & disk_sec512[1],
                                 switch_code(1'b0), switch_code(1'b1)};
               end
            end else begin
               r.read_data = UnmappedRead;
            end
         end
         REQ_LINE_EVENT: begin
            if (it.signal_id <= LastSignalId) begin
               lines_shadow[it.signal_id] = ~it.signal_level;
               touched = 1'b1;
            end
         end
         default: begin
            if (it.signal_level) begin
               ctl_shadow[CtlDmaeBit] = 1'b0;
               touched = 1'b1;
            end
         end
      endcase
      if (touched) update_requests(prev_ctl, prev_lines);
      r.rst_level = ctl_shadow[CtlRstBit];
      r.sel_level = ctl_shadow[CtlSelBit];
      r.irq       = irq_shadow;
      r.drq       = drq_shadow;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endfunction

   // Result side: check each accepted beat, then pick the next stall level.
   always @(posedge clock) begin : rsp_side
      rsp_item_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("result beat %h with no request outstanding", rsp_data);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            check_field("read_data", want.read_data, rsp_data.read_data);
            check_field("target_write", 8'(want.target_write), 8'(rsp_data.target_write));
            check_field("target_read", 8'(want.target_read), 8'(rsp_data.target_read));
            check_field("target_write_data", want.target_write_data,
                        rsp_data.target_write_data);
            check_field("rst_level", 8'(want.rst_level), 8'(rsp_data.rst_level));
            check_field("sel_level", 8'(want.sel_level), 8'(rsp_data.sel_level));
            check_field("irq", 8'(want.irq), 8'(rsp_data.irq));
            check_field("drq", 8'(want.drq), 8'(rsp_data.drq));
         end
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Offer one request beat and record its expected result once accepted.
   task automatic send_beat(input req_item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (req_stall !== 1'b0);
      pending_results.push_back(port_block_outcome(it));
   endtask

   // Stop offering and wait until every expected result has come back.
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // One APB write; the bus stays selected so that writes can follow back to back.
   task automatic csr_write(input cfg_index_type idx, input logic [11:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= 32'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      case (idx)
         CFG_DISK0_PRESENT:    disk_present[0] = value[0];
         CFG_DISK0_SIZE_MB:    disk_size_mb[0] = value;
         CFG_DISK0_FOUR_HEADS: disk_four_hd[0] = value[0];
         CFG_DISK0_SECTOR512:  disk_sec512[0]  = value[0];
         CFG_DISK1_PRESENT:    disk_present[1] = value[0];
         CFG_DISK1_SIZE_MB:    disk_size_mb[1] = value;
         CFG_DISK1_FOUR_HEADS: disk_four_hd[1] = value[0];
         default:              disk_sec512[1]  = value[0];
      endcase
   endtask

   task automatic apply_disk_setup(input logic p0, input logic [11:0] mb0, input logic h0,
                                   input logic s0, input logic p1, input logic [11:0] mb1,
                                   input logic h1, input logic s1);
      csr_write(CFG_DISK0_PRESENT, 12'(p0));
      csr_write(CFG_DISK0_SIZE_MB, mb0);
      csr_write(CFG_DISK0_FOUR_HEADS, 12'(h0));
      csr_write(CFG_DISK0_SECTOR512, 12'(s0));
      csr_write(CFG_DISK1_PRESENT, 12'(p1));
      csr_write(CFG_DISK1_SIZE_MB, mb1);
      csr_write(CFG_DISK1_FOUR_HEADS, 12'(h1));
      csr_write(CFG_DISK1_SECTOR512, 12'(s1));
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Directed beat; the target read data and bus status fields are random.
   function automatic req_item_type make_beat(input req_kind_type kind, input logic [15:0] addr,
                                              input logic [7:0] wdata, input logic [2:0] sig,
                                              input logic lvl);
      req_item_type b;
      b.req_type         = kind;
      b.port_addr        = addr;
      b.write_data       = wdata;
      b.signal_id        = sig;
      b.signal_level     = lvl;
      b.target_read_data = 8'($urandom);
      {b.bus_req, b.bus_bsy, b.bus_msg, b.bus_cd, b.bus_io} = 5'($urandom);
      return b;
   endfunction

   // Random beat, weighted toward the two mapped ports and known lines.
   function automatic req_item_type random_beat();
      req_item_type b;
      int           pick;
      logic [2:0]   sig;
      pick = $urandom_range(99);
      sig  = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
      b    = make_beat(REQ_TERM_COUNT, 16'($urandom), 8'($urandom), sig, 1'($urandom));
      if (pick < 25) b.req_type = REQ_PORT_WRITE;
      else if (pick < 55) b.req_type = REQ_PORT_READ;
      else if (pick < 90) b.req_type = REQ_LINE_EVENT;
      pick = $urandom_range(99);
      if (pick < 40) b.port_addr = DataPort;
      else if (pick < 85) b.port_addr = ControlPort;
      return b;
   endfunction

   function automatic logic [11:0] random_size();
      return ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(35));
   endfunction

   task automatic test_data_port();
      req_item_type b;
      send_beat(make_beat(REQ_PORT_WRITE, DataPort, 8'hFF, 3'd0, 1'b0));
      send_beat(make_beat(REQ_PORT_WRITE, DataPort, 8'h00, 3'd7, 1'b1));
      b = make_beat(REQ_PORT_READ, DataPort, 8'h5A, 3'd0, 1'b0);
      b.target_read_data = 8'h00;
      send_beat(b);
      send_beat(make_beat(REQ_PORT_READ, DataPort, 8'h00, 3'd0, 1'b0));
   endtask

   task automatic test_unmapped_ports();
      send_beat(make_beat(REQ_PORT_READ, 16'h0000, 8'h00, 3'd0, 1'b0));
      send_beat(make_beat(REQ_PORT_READ, 16'hFFFF, 8'hFF, 3'd0, 1'b0));
      send_beat(make_beat(REQ_PORT_READ, 16'h0083, 8'h00, 3'd0, 1'b0));
      send_beat(make_beat(REQ_PORT_WRITE, 16'hFF7D, 8'hFF, 3'd0, 1'b0));
   endtask

   // Control levels and the live-bus form of the status byte.
   task automatic test_control_and_status();
      req_item_type b;
      send_beat(make_beat(REQ_PORT_WRITE, ControlPort, 8'h6B, 3'd0, 1'b0));
      b = make_beat(REQ_PORT_READ, ControlPort, 8'h00, 3'd0, 1'b0);
      {b.bus_req, b.bus_bsy, b.bus_msg, b.bus_cd, b.bus_io} = '1;
      send_beat(b);
      {b.bus_req, b.bus_bsy, b.bus_msg, b.bus_cd, b.bus_io} = '0;
      send_beat(b);
      send_beat(make_beat(REQ_PORT_WRITE, ControlPort, 8'h00, 3'd0, 1'b0));
   endtask

   // Walk the glue network through its irq and drq edges.
   task automatic test_request_flags();
      send_beat(make_beat(REQ_PORT_WRITE, ControlPort, 8'h03, 3'd0, 1'b0));
      send_beat(make_beat(REQ_LINE_EVENT, DataPort, 8'h00, 3'd4, 1'b1));
      send_beat(make_beat(REQ_LINE_EVENT, DataPort, 8'h00, 3'd5, 1'b1));
      send_beat(make_beat(REQ_LINE_EVENT, DataPort, 8'h00, 3'd5, 1'b0));
      send_beat(make_beat(REQ_LINE_EVENT, DataPort, 8'h00, 3'd4, 1'b0));
      send_beat(make_beat(REQ_LINE_EVENT, DataPort, 8'h00, 3'd4, 1'b1));
      // An idle terminal count does nothing; an active one drops DMA enable.
      send_beat(make_beat(REQ_TERM_COUNT, DataPort, 8'h00, 3'd0, 1'b0));
      send_beat(make_beat(REQ_TERM_COUNT, DataPort, 8'h00, 3'd0, 1'b1));
      send_beat(make_beat(REQ_PORT_WRITE, ControlPort, 8'h00, 3'd0, 1'b0));
      send_beat(make_beat(REQ_PORT_WRITE, ControlPort, 8'h01, 3'd0, 1'b0));
      send_beat(make_beat(REQ_LINE_EVENT, DataPort, 8'h00, 3'd2, 1'b1));
      send_beat(make_beat(REQ_LINE_EVENT, DataPort, 8'h00, 3'd1, 1'b1));
      send_beat(make_beat(REQ_LINE_EVENT, DataPort, 8'h00, 3'd3, 1'b0));
      send_beat(make_beat(REQ_LINE_EVENT, DataPort, 8'h00, 3'd0, 1'b1));
      // Unknown line ids are dropped.
      send_beat(make_beat(REQ_LINE_EVENT, DataPort, 8'h00, 3'd6, 1'b1));
      send_beat(make_beat(REQ_LINE_EVENT, DataPort, 8'h00, 3'd7, 1'b0));
   endtask

   // Size bands and flags across both disks, read back as the switch byte.
   task automatic test_drive_switches();
      logic [11:0] sizes [14] = '{12'd0, 12'd4095, 12'd6, 12'd7, 12'd11, 12'd12, 12'd16,
                                  12'd17, 12'd21, 12'd21, 12'd22, 12'd31, 12'd32, 12'd4095};
      wait_until_drained();
      send_beat(make_beat(REQ_PORT_WRITE, ControlPort, 8'h00, 3'd0, 1'b0));
      for (int k = 0; k < 14; k += 2) begin
         wait_until_drained();
         apply_disk_setup(k != 12, sizes[4'(k)], k[1], 1'b1, 1'b1, sizes[4'(k + 1)],
                          ~k[1], k[2]);
         send_beat(make_beat(REQ_PORT_READ, ControlPort, 8'h00, 3'd0, 1'b0));
      end
      wait_until_drained();
   endtask

   task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
      wait_until_drained();
      apply_disk_setup(1'($urandom), random_size(), 1'($urandom), 1'($urandom),
                       1'($urandom), random_size(), 1'($urandom), 1'($urandom));
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (count) send_beat(random_beat());
   endtask

   // Long result-side hold while requests keep coming, then a full drain.
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_left     = 300;
      repeat (40) send_beat(random_beat());
      wait_until_drained();
   endtask

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      psel      <= 1'b0;
      penable   <= 1'b0;
      pwrite    <= 1'b0;
      paddr     <= '0;
      pwdata    <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 11;
      recv_idle_pct = 54;
      test_data_port();
      test_unmapped_ports();
      test_control_and_status();
      test_request_flags();
      test_drive_switches();
      test_random_traffic(480, 11, 54);
      test_random_traffic(480, 54, 11);
      test_backpressure();
      test_random_traffic(450, 0, 0);
      wait_until_drained();
      repeat (8) @(posedge clock);

      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("PASS sasi_host_adapter_ports_unit");
      end else begin
         $display("FAIL sasi_host_adapter_ports_unit");
      end
      $finish;
   end

endmodule
